>>> hdl/bitmap_page_allocator_assert.svh
// ---------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

	localparam int NUM_PAGES_DEF = 1024;
	localparam int MODE_W        = 2;
	localparam int PAGE_W        = 10;
	localparam int LEN_W         = 10;
	localparam int S_DATA_W      = 24;
	localparam int M_DATA_W      = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 2'd0,
		MODE_USED  = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [PAGE_W-1:0] page;
		logic [LEN_W-1:0]  run_length;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [PAGE_W-1:0] first_page;
		logic              bit_value;
	} res_t;

endpackage

>>> hdl/bitmap_page_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit allocator of contiguous page runs over a one-bit usage map.
// ---------------------------------------------------------------------------
// Input beats arrive on s_axis: tuser carries the mode (allocate run, mark
// used, mark free, read bit), tdata the page and the run length. Every input
// beat yields exactly one output beat on m_axis: tuser is the found flag,
// tdata the first page of the run and the read bit.
// A zero-length allocation is answered without a scan; any other scans the map
// from page 1 for a free run of its length, then marks the run; a failing one
// scans the whole map. The usage map has a single read port, scanned one
// page per cycle, and a single write port, which marks one page per cycle.
// One item is in work at a time; s_axis_tready is low meanwhile. After reset
// the usage map is cleared one page per cycle, with s_axis_tready low. A result
// waits in the output register while the receiver stalls; the next item may
// already be taken and worked on, and its result holds inside until the
// register frees.
// ---------------------------------------------------------------------------
`include "bitmap_page_allocator_assert.svh"

module bitmap_page_allocator #(
	parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// page [9:0], run_length [19:10], zero [23:20]
	input  logic [bpa_pkg::S_DATA_W-1:0] s_axis_tdata,
	// mode [1:0]
	input  logic [bpa_pkg::MODE_W-1:0]   s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// first_page [9:0], bit_value [10], zero [15:11]
	output logic [bpa_pkg::M_DATA_W-1:0] m_axis_tdata,
	// found [0]
	output logic                         m_axis_tuser
);

	import bpa_pkg::*;

	req_t req;
	res_t res;
	res_t out_q;
	logic res_vld, res_rdy;
	logic out_vld_q;

	assign req.mode       = mode_t'(s_axis_tuser);
	assign req.page       = s_axis_tdata[PAGE_W-1:0];
	assign req.run_length = s_axis_tdata[PAGE_W+LEN_W-1:PAGE_W];

	bpa_seq #(
		.NUM_PAGES (NUM_PAGES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_vld (s_axis_tvalid),
		.req_rdy (s_axis_tready),
		.req     (req),
		.res_vld (res_vld),
		.res_rdy (res_rdy),
		.res     (res)
	);

	// load the output register when empty or drained this cycle
	assign res_rdy = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_rdy) begin
			out_vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && res_rdy) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.found;
	assign m_axis_tdata  = {(M_DATA_W-PAGE_W-1)'(0), out_q.bit_value, out_q.first_page};

	`BPA_ASSERT_NOW(a_fail_page_zero, m_axis_tvalid && !m_axis_tuser,
		m_axis_tdata[PAGE_W-1:0] == '0, "failed or non-allocate beat carries a page")
	`BPA_ASSERT_NOW(a_found_no_bit, m_axis_tvalid && m_axis_tuser,
		!m_axis_tdata[PAGE_W], "allocation beat carries a read bit")
	`BPA_ASSERT_NEXT(a_one_in_work, s_axis_tvalid && s_axis_tready,
		!s_axis_tready, "input taken while an item is in work")

endmodule

>>> hdl/bpa_ram.sv
// ---------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/bpa_seq.sv
// ---------------------------------------------------------------------------
// bpa_seq
// Sequencer of the allocator: one address counter walks the usage map for
// the clearing pass, the first-fit scan and the marking of a run.
// ---------------------------------------------------------------------------
module bpa_seq #(
	parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_vld,
	output logic          req_rdy,
	input  bpa_pkg::req_t req,
	output logic          res_vld,
	input  logic          res_rdy,
	output bpa_pkg::res_t res
);

	import bpa_pkg::*;

	localparam int AW    = $clog2(NUM_PAGES);
	localparam int CNT_W = $clog2(NUM_PAGES + 1);
	localparam int RW    = (CNT_W > PAGE_W) ? CNT_W : PAGE_W;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_MARK  = 6'b001000,
		ST_READ  = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	function automatic logic page_ok(input logic [PAGE_W-1:0] p);
		return RW'(p) < RW'(NUM_PAGES);
	endfunction

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  ptr_q, ptr_d;
	logic              chk_vld_q, chk_vld_d;
	logic [AW-1:0]     chk_addr_q;
	logic [LEN_W-1:0]  run_q, run_d;
	logic [LEN_W-1:0]  left_q, left_d;
	logic [AW-1:0]     start_q, start_d, start_nxt;
	logic [LEN_W:0]    run_nxt;
	req_t              req_q;
	res_t              res_q, res_d;
	logic              res_ld;
	logic              we, wdata, rdata;
	logic [AW-1:0]     waddr, raddr;

	bpa_ram #(
		.WIDTH (1),
		.DEPTH (NUM_PAGES)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign run_nxt   = {1'b0, run_q} + (LEN_W+1)'(1);
	assign start_nxt = (run_q == '0) ? chk_addr_q : start_q;

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		chk_vld_d = 1'b0;
		run_d     = run_q;
		left_d    = left_q;
		start_d   = start_q;
		we        = 1'b0;
		waddr     = ptr_q[AW-1:0];
		wdata     = 1'b0;
		raddr     = ptr_q[AW-1:0];
		res_ld    = 1'b0;
		res_d     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				ptr_d = ptr_q + CNT_W'(1);
				if (ptr_q == CNT_W'(NUM_PAGES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_vld) begin
					unique case (req.mode) inside
						MODE_ALLOC: begin
							if (req.run_length == '0) begin
								res_ld  = 1'b1;
								state_d = ST_RESP;
							end else begin
								ptr_d   = CNT_W'(1);
								run_d   = '0;
								state_d = ST_SCAN;
							end
						end
						MODE_USED, MODE_FREE: begin
							we      = page_ok(req.page);
							waddr   = AW'(req.page);
							wdata   = (req.mode == MODE_USED);
							res_ld  = 1'b1;
							state_d = ST_RESP;
						end
						default: begin
							raddr   = AW'(req.page);
							state_d = ST_READ;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// issue one read a cycle, judge the bit read the cycle before
				if (ptr_q < CNT_W'(NUM_PAGES)) begin
					chk_vld_d = 1'b1;
					ptr_d     = ptr_q + CNT_W'(1);
				end
				if (chk_vld_q) begin
					if (!rdata) begin
						start_d = start_nxt;
						run_d   = run_nxt[LEN_W-1:0];
						if (run_nxt >= {1'b0, req_q.run_length}) begin
							ptr_d     = CNT_W'(start_nxt);
							left_d    = req_q.run_length;
							chk_vld_d = 1'b0;
							state_d   = ST_MARK;
						end
					end else begin
						run_d = '0;
					end
				end else if (ptr_q >= CNT_W'(NUM_PAGES)) begin
					res_ld  = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_MARK: begin
				we     = 1'b1;
				wdata  = 1'b1;
				ptr_d  = ptr_q + CNT_W'(1);
				left_d = left_q - LEN_W'(1);
				if (left_q == LEN_W'(1)) begin
					res_ld           = 1'b1;
					res_d.found      = 1'b1;
					res_d.first_page = PAGE_W'(start_q);
					state_d          = ST_RESP;
				end
			end
			ST_READ: begin
				res_ld          = 1'b1;
				res_d.bit_value = rdata & page_ok(req_q.page);
				state_d         = ST_RESP;
			end
			ST_RESP: begin
				if (res_rdy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			ptr_q     <= '0;
			chk_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ptr_q     <= ptr_d;
			chk_vld_q <= chk_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		chk_addr_q <= ptr_q[AW-1:0];
		run_q      <= run_d;
		left_q     <= left_d;
		start_q    <= start_d;
		if (req_vld && req_rdy) begin
			req_q <= req;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	assign req_rdy = (state_q == ST_IDLE);
	assign res_vld = (state_q == ST_RESP);
	assign res     = res_q;

endmodule

>>> dv/bitmap_page_allocator_tb.sv
// ---------------------------------------------------------------------------
// bitmap_page_allocator_tb
// Drives allocate, mark-used, mark-free and read-bit requests into the page
// allocator. A scoreboard keeps its own usage map, works out the reply to
// every accepted request and compares it with the reply beats in order.
// ---------------------------------------------------------------------------
module bitmap_page_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpa_pkg::*;

	localparam int PAGES      = NUM_PAGES_DEF;
	localparam int REQ_TOTAL  = 290;
	localparam int TIMEOUT_NS = 42_000_000;

	class page_map_scoreboard;
		bit   page_used [PAGES];
		res_t reply_q [$];
		int   errors;
		int   allocs;
		int   grants;
		int   marks;
		int   reads;

		// Allocations: first-fit scan from page 1, then claim the run; marks, frees and reads act on one page.
		function void take_request(mode_t m, logic [PAGE_W-1:0] pg,
				logic [LEN_W-1:0] len);
			res_t r;
			int   start;
			int   run;
			bit   hit;
			r     = '0;
			start = 0;
			run   = 0;
			hit   = 1'b0;
			case (m)
				MODE_ALLOC: begin
					allocs++;
					if (len != 0) begin
						for (int i = 1; i < PAGES && !hit; i++) begin
							if (!page_used[i]) begin
								if (run == 0)
									start = i;
								run++;
								if (run >= len)
									hit = 1'b1;
							end else begin
								run = 0;
							end
						end
					end
					if (hit) begin
						for (int k = 0; k < len; k++)
							if (start + k < PAGES)
								page_used[start + k] = 1'b1;
						grants++;
						r.found      = 1'b1;
						r.first_page = start[PAGE_W-1:0];
					end
				end
				MODE_USED: begin
					marks++;
					page_used[pg] = 1'b1;
				end
				MODE_FREE: begin
					marks++;
					page_used[pg] = 1'b0;
				end
				default: begin
					reads++;
					r.bit_value = page_used[pg];
				end
			endcase
			reply_q.push_back(r);
		endfunction

		function void check_reply(logic fnd, logic [PAGE_W-1:0] fp, logic bv);
			res_t e;
			if (reply_q.size() == 0) begin
				$display("%0t: reply beat with none pending: expected nothing,",
					$time);
				$display("    actual found=%0d first_page=%0d bit_value=%0d",
					fnd, fp, bv);
				errors++;
				return;
			end
			e = reply_q.pop_front();
			if (fnd !== e.found) begin
				$display("%0t: found mismatch: expected %0d, actual %0d", $time, e.found, fnd);
				errors++;
			end
			if (fp !== e.first_page) begin
				$display("%0t: first_page mismatch: expected %0d, actual %0d",
					$time, e.first_page, fp);
				errors++;
			end
			if (bv !== e.bit_value) begin
				$display("%0t: bit_value mismatch: expected %0d, actual %0d",
					$time, e.bit_value, bv);
				errors++;
			end
		endfunction

		function int pending();
			return reply_q.size();
		endfunction
	endclass

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	logic [MODE_W-1:0]   s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic                m_axis_tuser;

	int send_idle = 0;
	int recv_idle = 0;
	int sent      = 0;

	page_map_scoreboard sb = new();

	bitmap_page_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_reply(m_axis_tuser, m_axis_tdata[PAGE_W-1:0], m_axis_tdata[PAGE_W]);
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Present one request beat and hold it until accepted.
	task automatic issue_request(input mode_t m, input logic [PAGE_W-1:0] pg,
			input logic [LEN_W-1:0] len);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= {{(S_DATA_W-PAGE_W-LEN_W){1'b0}}, len, pg};
		do @(posedge clk); while (!s_axis_tready);
		sb.take_request(m, pg, len);
		sent++;
	endtask

	// Hold off the sender until every reply is back.
	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Mostly the low window where runs come and go, sometimes anywhere.
	function automatic logic [PAGE_W-1:0] pick_page();
		if ($urandom_range(3) != 0)
			return PAGE_W'($urandom_range(255));
		return PAGE_W'($urandom_range(PAGES - 1));
	endfunction

	initial begin
		int               base;
		int               quota;
		int               n;
		logic [PAGE_W-1:0] pg;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 37;
		recv_idle = 51;

		// Directed: zero length, page zero, exact fit, top page, no room.
		issue_request(MODE_ALLOC, 0, 0);
		issue_request(MODE_ALLOC, 0, 1);
		issue_request(MODE_ALLOC, 0, 3);
		issue_request(MODE_USED, 0, 0);
		issue_request(MODE_READ, 0, 0);
		issue_request(MODE_ALLOC, 0, 1);
		issue_request(MODE_FREE, 0, 0);
		issue_request(MODE_READ, 0, 0);
		issue_request(MODE_USED, 12, 0);
		issue_request(MODE_ALLOC, 0, 8);
		issue_request(MODE_ALLOC, 0, 6);
		issue_request(MODE_USED, 1023, 0);
		issue_request(MODE_READ, 1023, 0);
		issue_request(MODE_READ, 1022, 0);
		issue_request(MODE_ALLOC, 0, 1023);
		issue_request(MODE_FREE, 1023, 0);
		issue_request(MODE_FREE, 2, 0);
		issue_request(MODE_ALLOC, 0, 1);
		issue_request(MODE_ALLOC, 1023, 1002);
		issue_request(MODE_ALLOC, 0, 2);
		issue_request(MODE_ALLOC, 0, 1);
		issue_request(MODE_READ, 1023, 0);
		drain_replies();

		base = sent;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 37;
					recv_idle = 51;
				end
				1: begin
					send_idle = 51;
					recv_idle = 37;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			quota = base + (phase + 1) * (REQ_TOTAL - base) / 3;
			while (sent < quota) begin
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						if ($urandom_range(4) == 0)
							issue_request(MODE_ALLOC, PAGE_W'($urandom_range(1023)),
								LEN_W'($urandom_range(1, 40)));
						else
							issue_request(MODE_ALLOC, PAGE_W'($urandom_range(1023)),
								LEN_W'($urandom_range(1, 8)));
					end
					4, 5: begin
						// Open a hole: free a short stretch of pages.
						pg = pick_page();
						n  = $urandom_range(2, 8);
						for (int k = 0; k < n; k++)
							issue_request(MODE_FREE, pg + k[PAGE_W-1:0],
								LEN_W'($urandom_range(1023)));
					end
					6: issue_request(MODE_USED, pick_page(), LEN_W'($urandom_range(1023)));
					7: issue_request(MODE_READ, pick_page(), LEN_W'($urandom_range(1023)));
					default: issue_request(mode_t'(MODE_W'($urandom_range(3))),
						PAGE_W'($urandom_range(1023)), LEN_W'($urandom_range(1023)));
				endcase
			end
			drain_replies();
		end

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Ran %0d requests: %0d allocations (%0d granted), %0d marks, %0d reads,",
			sent, sb.allocs, sb.grants, sb.marks, sb.reads);
		$display("under three sender/receiver stall patterns with full drains between them.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("bitmap_page_allocator_tb: PASS");
		end else begin
			$display("bitmap_page_allocator_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("bitmap_page_allocator_tb: FAIL");
		$finish;
	end

endmodule
